// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the hashed page table RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge.
`define HPT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// A consequence that holds in the same cycle as its trigger.
`define HPT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that holds in the cycle after its trigger.
`define HPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/hpt_pkg.sv =====
// Package for the hashed page table: field widths, codes and item types.
// Used by hpt_mod_unit and hashed_page_table_top; depends on nothing.
`default_nettype none

package hpt_pkg;

  // Fixed field widths of the request and response items.
  localparam int MODE_W   = 2;
  localparam int PAGE_W   = 20;
  localparam int FRAME_W  = 16;
  localparam int STATUS_W = 2;
  localparam int BUCKET_W = 6;
  localparam int ENTRY_W  = 10;
  localparam int CFG_W    = 7;

  // Bucket count after reset.
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

  // Response status codes.
  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // One request item.
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } req_t;

  // One response item.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  found_frame;
    logic [BUCKET_W-1:0] bucket_index;
    logic [ENTRY_W-1:0]  entry_count;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hpt_mod_unit.sv =====
// Iterative remainder unit: page modulo bucket count, two dividend bits a cycle.
// Depends on hpt_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module hpt_mod_unit #(
  parameter int MAX_BUCKETS = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  input  wire logic [hpt_pkg::PAGE_W-1:0]             dividend,
  input  wire logic [$clog2(MAX_BUCKETS+1)-1:0]       divisor,
  output logic                                        done,
  output logic [(MAX_BUCKETS > 1 ? $clog2(MAX_BUCKETS) : 1)-1:0] remainder
);

  localparam int PAGE_W  = hpt_pkg::PAGE_W;
  localparam int BKT_W   = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int STEPS   = (PAGE_W + 1) / 2;
  localparam int DIV_W   = 2 * STEPS;
  localparam int STEP_W  = $clog2(STEPS + 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DIV_W-1:0]  shift;
  logic [BKT_W-1:0]  rem;
  logic [BKT_W:0]    dvs_ext;
  logic [BKT_W:0]    trial_hi;
  logic [BKT_W:0]    trial_lo;
  logic [BKT_W-1:0]  rem_mid;
  logic [BKT_W-1:0]  rem_next;

  // Two restoring steps per cycle; the partial remainder stays below the divisor.
  always_comb begin
    dvs_ext  = (BKT_W+1)'(divisor);
    trial_hi = {rem, shift[DIV_W-1]};
    rem_mid  = (trial_hi >= dvs_ext) ? BKT_W'(trial_hi - dvs_ext) : BKT_W'(trial_hi);
    trial_lo = {rem_mid, shift[DIV_W-2]};
    rem_next = (trial_lo >= dvs_ext) ? BKT_W'(trial_lo - dvs_ext) : BKT_W'(trial_lo);
  end

  // Step counter and control flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Dividend shifter and partial remainder.
  always_ff @(posedge clk) begin
    if (start) begin
      shift <= DIV_W'(dividend);
      rem   <= '0;
    end else if (busy) begin
      shift <= shift << 2;
      rem   <= rem_next;
    end
  end

  assign remainder = rem;

  `HPT_ASSERT_IMPL(a_start_idle, start, !busy, "remainder unit started while busy")
  `HPT_ASSERT_IMPL(a_done_idle, done, !busy, "done raised while still stepping")
  `HPT_ASSERT_NEXT(a_done_pulse, done, !done, "done held for more than one cycle")

endmodule

`default_nettype wire

// ===== hw/rtl/hashed_page_table_top.sv =====
// Hashed page table top level: request FSM, bucket row memory and live count.
// Depends on hpt_pkg, hpt_mod_unit and assert_macros.svh.
//
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  hpt_pkg::req_t (mode, page, frame)
// rsp      out        rsp_valid / rsp_ready  hpt_pkg::rsp_t (status, frame, bucket, count)
// cfg      in         cfg_wr_en              cfg_wr_data: bucket count, 7 bits
//
// Lookup and insert run 10 remainder steps, then row read, evaluate, output load
// and idle. Delete reads one row a cycle until a frame match or the last bucket.
// Clear drops all the per-row live flags together, without a pass over the rows.
// Reset is synchronous; the table is empty right after it, with no clearing pass.
// A finished item waits in the output register; a new request can be accepted
// meanwhile, and the next result stalls only until the register is taken.
`default_nettype none

`include "assert_macros.svh"

module hashed_page_table_top #(
  parameter int MAX_BUCKETS      = 64,
  parameter int SLOTS_PER_BUCKET = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [hpt_pkg::CFG_W-1:0]    cfg_wr_data,
  input  wire logic                         req_valid,
  output logic                              req_ready,
  input  wire hpt_pkg::req_t                req,
  output logic                              rsp_valid,
  input  wire logic                         rsp_ready,
  output hpt_pkg::rsp_t                     rsp
);

  localparam int PAGE_W      = hpt_pkg::PAGE_W;
  localparam int FRAME_W     = hpt_pkg::FRAME_W;
  localparam int BUCKET_W    = hpt_pkg::BUCKET_W;
  localparam int ENTRY_W     = hpt_pkg::ENTRY_W;
  localparam int NB_W        = $clog2(MAX_BUCKETS + 1);
  localparam int BKT_W       = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int SLOT_W      = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int TOTAL_SLOTS = MAX_BUCKETS * SLOTS_PER_BUCKET;
  localparam int CNT_W       = $clog2(TOTAL_SLOTS + 1);

  typedef struct packed {
    logic               valid;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } slot_t;

  typedef slot_t [SLOTS_PER_BUCKET-1:0] row_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HASH = 5'b00010,
    S_EVAL = 5'b00100,
    S_SCAN = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  // Lowest set bit of a slot vector.
  function automatic logic [SLOT_W-1:0] first_set(input logic [SLOTS_PER_BUCKET-1:0] v);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int s = SLOTS_PER_BUCKET - 1; s >= 0; s--) begin
      if (v[s]) idx = SLOT_W'(s);
    end
    return idx;
  endfunction

  state_t                     state;
  state_t                     state_next;
  logic [hpt_pkg::CFG_W-1:0]  bucket_count;
  logic [NB_W-1:0]            nb;
  logic [31:0]                cfg_ext;
  hpt_pkg::req_t              req_q;
  hpt_pkg::req_t              req_q_next;
  hpt_pkg::rsp_t              res_q;
  hpt_pkg::rsp_t              res_q_next;
  logic [CNT_W-1:0]           live;
  logic [CNT_W-1:0]           live_next;
  logic [MAX_BUCKETS-1:0]     row_live;
  logic                       clear_rows;
  logic                       finish;
  logic                       out_free;

  // Row memory and its ports.
  row_t                       mem [MAX_BUCKETS];
  row_t                       mem_q;
  row_t                       row_data;
  row_t                       mem_wdata;
  logic                       mem_we;
  logic                       rd_en;
  logic [BKT_W-1:0]           rd_addr;
  logic [BKT_W-1:0]           rd_bkt_q;
  logic                       rd_live_q;

  // Per-slot match vectors of the row being evaluated.
  logic [SLOTS_PER_BUCKET-1:0] page_hit;
  logic [SLOTS_PER_BUCKET-1:0] frame_hit;
  logic [SLOTS_PER_BUCKET-1:0] slot_free;
  logic [SLOT_W-1:0]           page_idx;
  logic [SLOT_W-1:0]           frame_idx;
  logic [SLOT_W-1:0]           free_idx;
  logic                        last_bkt;

  // Remainder unit interface.
  logic                        mod_start;
  logic                        mod_done;
  logic [BKT_W-1:0]            mod_rem;

  hpt_mod_unit #(
    .MAX_BUCKETS(MAX_BUCKETS)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (req.page),
    .divisor   (nb),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // Bucket count register; zero counts as one, large values saturate.
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= hpt_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      bucket_count <= cfg_wr_data;
    end
  end

  always_comb begin
    cfg_ext = 32'(bucket_count);
    if (cfg_ext == 32'd0) begin
      nb = NB_W'(1);
    end else if (cfg_ext > 32'(MAX_BUCKETS)) begin
      nb = NB_W'(MAX_BUCKETS);
    end else begin
      nb = NB_W'(cfg_ext);
    end
  end

  // Synchronous row memory, one read and one write port, registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[rd_bkt_q] <= mem_wdata;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // A row whose live flag is clear reads as all slots empty.
  assign row_data = rd_live_q ? mem_q : '0;

  always_comb begin
    for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
      page_hit[s]  = row_data[s].valid && (row_data[s].page == req_q.page);
      frame_hit[s] = row_data[s].valid && (row_data[s].frame == req_q.frame);
      slot_free[s] = !row_data[s].valid;
    end
    page_idx  = first_set(page_hit);
    frame_idx = first_set(frame_hit);
    free_idx  = first_set(slot_free);
    last_bkt  = ((NB_W+1)'(rd_bkt_q) + (NB_W+1)'(1)) == (NB_W+1)'(nb);
  end

  assign req_ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;

  // Request sequencer: hash, read the row, evaluate and write back, respond; delete scans rows, clear answers at once.
  always_comb begin
    state_next = state;
    req_q_next = req_q;
    res_q_next = res_q;
    live_next  = live;
    mem_we     = 1'b0;
    mem_wdata  = row_data;
    rd_en      = 1'b0;
    rd_addr    = '0;
    mod_start  = 1'b0;
    clear_rows = 1'b0;
    finish     = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          req_q_next = req;
          case (req.mode)
            hpt_pkg::MODE_LOOKUP, hpt_pkg::MODE_INSERT: begin
              mod_start  = 1'b1;
              state_next = S_HASH;
            end
            hpt_pkg::MODE_DELETE: begin
              rd_en      = 1'b1;
              rd_addr    = '0;
              state_next = S_SCAN;
            end
            hpt_pkg::MODE_CLEAR: begin
              clear_rows = 1'b1;
              live_next  = '0;
              res_q_next = '{status: hpt_pkg::ST_DONE, default: '0};
              finish     = 1'b1;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_HASH: begin
        if (mod_done) begin
          rd_en      = 1'b1;
          rd_addr    = mod_rem;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        res_q_next = '{status: hpt_pkg::ST_DONE, default: '0};
        res_q_next.bucket_index = BUCKET_W'(rd_bkt_q);
        if (req_q.mode == hpt_pkg::MODE_LOOKUP) begin
          if (|page_hit) begin
            res_q_next.found_frame = row_data[page_idx].frame;
          end else begin
            res_q_next.status = hpt_pkg::ST_MISS;
          end
        end else if (|slot_free) begin
          mem_we                    = 1'b1;
          mem_wdata[free_idx].valid = 1'b1;
          mem_wdata[free_idx].page  = req_q.page;
          mem_wdata[free_idx].frame = req_q.frame;
          live_next                 = live + CNT_W'(1);
        end else begin
          res_q_next.status = hpt_pkg::ST_FULL;
        end
        finish = 1'b1;
      end
      S_SCAN: begin
        if (|frame_hit) begin
          mem_we                     = 1'b1;
          mem_wdata[frame_idx].valid = 1'b0;
          if (live != '0) begin
            live_next = live - CNT_W'(1);
          end
          res_q_next = '{status: hpt_pkg::ST_DONE, default: '0};
          res_q_next.bucket_index = BUCKET_W'(rd_bkt_q);
          finish = 1'b1;
        end else if (last_bkt) begin
          res_q_next = '{status: hpt_pkg::ST_MISS, default: '0};
          finish     = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = rd_bkt_q + BKT_W'(1);
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (finish) begin
      res_q_next.entry_count = ENTRY_W'(live_next);
      state_next             = S_RESP;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      live      <= '0;
      row_live  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      live  <= live_next;
      if (clear_rows) begin
        row_live <= '0;
      end else if (mem_we) begin
        row_live[rd_bkt_q] <= 1'b1;
      end
      if (state == S_RESP && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_q <= req_q_next;
    res_q <= res_q_next;
    if (rd_en) begin
      rd_bkt_q  <= rd_addr;
      rd_live_q <= row_live[rd_addr];
    end
    if (state == S_RESP && out_free) begin
      rsp <= res_q;
    end
  end

  `HPT_ASSERT_ALWAYS(a_live_max, live <= CNT_W'(TOTAL_SLOTS), "live count above table size")
  `HPT_ASSERT_IMPL(a_mod_done_hash, mod_done, state == S_HASH, "remainder done outside hash")
  `HPT_ASSERT_IMPL(a_write_state, mem_we, state == S_EVAL || state == S_SCAN, "row write out of turn")
  `HPT_ASSERT_NEXT(a_clear_empty, req_valid && req_ready && req.mode == hpt_pkg::MODE_CLEAR, live == '0, "clear left live entries")

endmodule

`default_nettype wire
